### src/int8_matmul_with_zero_points_core_macros.svh
// Assertion macros shared by the int8 matmul core.
// No dependencies; included by the modules that carry assertions.
`ifndef INT8_MATMUL_WITH_ZERO_POINTS_CORE_MACROS_SVH
`define INT8_MATMUL_WITH_ZERO_POINTS_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define I8MMZP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define I8MMZP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define I8MMZP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define I8MMZP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/i8mmzp_pkg.sv
// Package of the int8 matmul core: widths, codes, control structs, helpers.
// No dependencies.
`timescale 1ns / 1ps

package i8mmzp_pkg;

	localparam int DEF_MAX_M = 64;
	localparam int DEF_MAX_K = 64;
	localparam int DEF_MAX_N = 64;

	localparam int DIM_W      = 7;
	localparam int OP_W       = 3;
	localparam int IDX_W      = 6;
	localparam int ELEM_W     = 8;
	localparam int SUM_W      = 32;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int DIFF_W     = 9;
	localparam int PROD_W     = 18;

	localparam logic [OP_W-1:0] OP_LOAD_A   = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B   = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_AZP = 3'd2;
	localparam logic [OP_W-1:0] OP_LOAD_BZP = 3'd3;
	localparam logic [OP_W-1:0] OP_COMPUTE  = 3'd4;

	localparam logic [1:0] ZP_NONE   = 2'd0;
	localparam logic [1:0] ZP_SCALAR = 2'd1;
	localparam logic [1:0] ZP_PER    = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_DIM_M       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIM_K       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIM_N       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A_IS_SIGNED = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_B_IS_SIGNED = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_A_ZERO_MODE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_B_ZERO_MODE = 3'd6;

	typedef struct packed {
		logic [DIM_W-1:0] dim_m;
		logic [DIM_W-1:0] dim_k;
		logic [DIM_W-1:0] dim_n;
		logic             a_is_signed;
		logic             b_is_signed;
		logic [1:0]       a_zero_mode;
		logic [1:0]       b_zero_mode;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic we_a;
		logic we_b;
		logic we_azp;
		logic we_bzp;
		logic start;     // latch row, read A zero point, clear accumulators
		logic rd_en;     // issue one reduction step
		logic out_load;  // copy one accumulator into the output register
		logic out_last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
	} status_t;

	// Last valid index of a dimension: 0 acts as 1, above max acts as max.
	function automatic logic [7:0] last_index(input logic [DIM_W-1:0] dim,
			input int unsigned max_v);
		logic [8:0] d9;
		logic [8:0] m9;
		d9 = 9'(dim);
		m9 = 9'(max_v);
		if (d9 == 9'd0) begin
			last_index = 8'd0;
		end else if (d9 > m9) begin
			last_index = 8'(m9 - 9'd1);
		end else begin
			last_index = 8'(d9 - 9'd1);
		end
	endfunction

	function automatic logic signed [DIFF_W-1:0] widen(input logic [ELEM_W-1:0] raw,
			input logic sgn);
		widen = {sgn & raw[ELEM_W-1], raw};
	endfunction

endpackage

### src/i8mmzp_if.sv
// Channel interfaces of the int8 matmul core: item, result, config write.
// Depends on i8mmzp_pkg for field widths.
`timescale 1ns / 1ps

interface i8mmzp_item_if;
	logic                           valid;
	logic                           ready;
	logic [i8mmzp_pkg::OP_W-1:0]    op;
	logic [i8mmzp_pkg::IDX_W-1:0]   row_index;
	logic [i8mmzp_pkg::IDX_W-1:0]   col_index;
	logic [i8mmzp_pkg::ELEM_W-1:0]  elem_value;
	modport source(output valid, op, row_index, col_index, elem_value, input ready);
	modport sink(input valid, op, row_index, col_index, elem_value, output ready);
endinterface

interface i8mmzp_result_if;
	logic                                valid;
	logic                                ready;
	logic [i8mmzp_pkg::IDX_W-1:0]        out_row;
	logic [i8mmzp_pkg::IDX_W-1:0]        out_col;
	logic signed [i8mmzp_pkg::SUM_W-1:0] dot_sum;
	logic                                is_last;
	modport source(output valid, out_row, out_col, dot_sum, is_last, input ready);
	modport sink(input valid, out_row, out_col, dot_sum, is_last, output ready);
endinterface

interface i8mmzp_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [i8mmzp_pkg::REG_IDX_W-1:0]   index;
	logic [i8mmzp_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/int8_matmul_with_zero_points_core.sv
// Top level of the int8 matmul core with zero points.
// Depends on i8mmzp_pkg, the channel interfaces, i8mmzp_cfg, i8mmzp_ctrl, i8mmzp_dp.
`timescale 1ns / 1ps

// Computes one row of Y = (A - a_zp) x (B - b_zp) per compute transaction,
// int8 or uint8 operands per config, 9-bit differences, 32-bit signed sums.
// Load transactions (A element, B element, A or B zero point) produce
// nothing. A compute transaction for a row in range runs the reduction
// steps, reading A one byte a step while a full row of B (MAX_N bytes)
// feeds MAX_N MAC lanes in parallel, then drains the MAC pipeline, then
// emits one result per cycle out of the accumulator bank, slower if the
// sink stalls. The item channel is not ready while a row is in flight;
// the last result of a row may still be waiting in the output register
// while the next transaction is taken. Stores come up undefined: read
// only entries you have written. Config writes are taken every cycle and
// must only happen while idle.

module int8_matmul_with_zero_points_core #(
	parameter int MAX_M = i8mmzp_pkg::DEF_MAX_M,
	parameter int MAX_K = i8mmzp_pkg::DEF_MAX_K,
	parameter int MAX_N = i8mmzp_pkg::DEF_MAX_N
) (
	input  logic                   clk,
	input  logic                   arst_n,
	i8mmzp_item_if.sink            item,
	i8mmzp_result_if.source        result,
	i8mmzp_cfg_if.sink             cfg
);

	localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int NW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	i8mmzp_pkg::cfg_t    cfg_regs;
	i8mmzp_pkg::cmd_t    cmd;
	i8mmzp_pkg::status_t status;
	logic [KW-1:0]       rd_k;
	logic [NW-1:0]       out_col;

	// config registers: written on each valid config transaction
	i8mmzp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// sequencer: decodes items, steps the reduction, paces the results
	i8mmzp_ctrl #(
		.MAX_M (MAX_M),
		.MAX_K (MAX_K),
		.MAX_N (MAX_N)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_regs),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.op           (item.op),
		.row_index    (item.row_index),
		.col_index    (item.col_index),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.rd_k         (rd_k),
		.out_col      (out_col),
		.status       (status)
	);

	// stores, MAC lanes and output register
	i8mmzp_dp #(
		.MAX_M (MAX_M),
		.MAX_K (MAX_K),
		.MAX_N (MAX_N)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_regs),
		.row_index  (item.row_index),
		.col_index  (item.col_index),
		.elem_value (item.elem_value),
		.cmd        (cmd),
		.rd_k       (rd_k),
		.out_col    (out_col),
		.status     (status),
		.res_row    (result.out_row),
		.res_col    (result.out_col),
		.res_sum    (result.dot_sum),
		.res_last   (result.is_last)
	);

endmodule

### src/i8mmzp_cfg.sv
// Configuration register file of the int8 matmul core.
// Depends on i8mmzp_pkg.
`timescale 1ns / 1ps

module i8mmzp_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_valid,
	output logic                               wr_ready,
	input  logic [i8mmzp_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [i8mmzp_pkg::CFG_DATA_W-1:0]  wr_data,
	output i8mmzp_pkg::cfg_t                   cfg
);

	i8mmzp_pkg::cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_m       <= 7'd1;
			cfg_q.dim_k       <= 7'd1;
			cfg_q.dim_n       <= 7'd1;
			cfg_q.a_is_signed <= 1'b1;
			cfg_q.b_is_signed <= 1'b1;
			cfg_q.a_zero_mode <= i8mmzp_pkg::ZP_NONE;
			cfg_q.b_zero_mode <= i8mmzp_pkg::ZP_NONE;
		end else if (wr_valid) begin
			unique case (wr_index)
				i8mmzp_pkg::REG_DIM_M:       cfg_q.dim_m       <= wr_data;
				i8mmzp_pkg::REG_DIM_K:       cfg_q.dim_k       <= wr_data;
				i8mmzp_pkg::REG_DIM_N:       cfg_q.dim_n       <= wr_data;
				i8mmzp_pkg::REG_A_IS_SIGNED: cfg_q.a_is_signed <= wr_data[0];
				i8mmzp_pkg::REG_B_IS_SIGNED: cfg_q.b_is_signed <= wr_data[0];
				i8mmzp_pkg::REG_A_ZERO_MODE: cfg_q.a_zero_mode <= wr_data[1:0];
				i8mmzp_pkg::REG_B_ZERO_MODE: cfg_q.b_zero_mode <= wr_data[1:0];
				default: ;
			endcase
		end
	end

endmodule

### src/i8mmzp_dp.sv
// Datapath of the int8 matmul core: operand stores, zero points, N-lane MAC
// bank and output register. Depends on i8mmzp_pkg.
`timescale 1ns / 1ps

module i8mmzp_dp #(
	parameter int MAX_M = i8mmzp_pkg::DEF_MAX_M,
	parameter int MAX_K = i8mmzp_pkg::DEF_MAX_K,
	parameter int MAX_N = i8mmzp_pkg::DEF_MAX_N,
	localparam int MW = (MAX_M > 1) ? $clog2(MAX_M) : 1,
	localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1,
	localparam int NW = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  i8mmzp_pkg::cfg_t                     cfg,
	input  logic [i8mmzp_pkg::IDX_W-1:0]         row_index,
	input  logic [i8mmzp_pkg::IDX_W-1:0]         col_index,
	input  logic [i8mmzp_pkg::ELEM_W-1:0]        elem_value,
	input  i8mmzp_pkg::cmd_t                     cmd,
	input  logic [KW-1:0]                        rd_k,
	input  logic [NW-1:0]                        out_col,
	output i8mmzp_pkg::status_t                  status,
	output logic [i8mmzp_pkg::IDX_W-1:0]         res_row,
	output logic [i8mmzp_pkg::IDX_W-1:0]         res_col,
	output logic signed [i8mmzp_pkg::SUM_W-1:0]  res_sum,
	output logic                                 res_last
);

	localparam int EW = i8mmzp_pkg::ELEM_W;
	localparam int DW = i8mmzp_pkg::DIFF_W;
	localparam int PW = i8mmzp_pkg::PROD_W;
	localparam int SW = i8mmzp_pkg::SUM_W;

	logic [EW-1:0]          a_mem [MAX_M][MAX_K];
	logic [MAX_N*EW-1:0]    b_mem [MAX_K];
	logic [EW-1:0]          azp_mem [MAX_M];
	logic [EW-1:0]          bzp_q [MAX_N];

	logic [i8mmzp_pkg::IDX_W-1:0] row_q;
	logic [EW-1:0]                azp_raw_q;
	logic [EW-1:0]                a_rd_s1;
	logic [MAX_N*EW-1:0]          b_rd_s1;
	logic                         v_s1;
	logic                         v_s2;
	logic signed [PW-1:0]         prod_s2 [MAX_N];
	logic signed [SW-1:0]         acc_q [MAX_N];
	logic signed [DW-1:0]         azp;
	logic signed [DW-1:0]         da;

	// operand stores, byte-wide writes, registered reads
	always_ff @(posedge clk) begin
		if (cmd.we_a) begin
			a_mem[MW'(row_index)][KW'(col_index)] <= elem_value;
		end
		a_rd_s1 <= a_mem[MW'(row_q)][rd_k];
	end

	always_ff @(posedge clk) begin
		if (cmd.we_b) begin
			b_mem[KW'(row_index)][NW'(col_index)*EW +: EW] <= elem_value;
		end
		b_rd_s1 <= b_mem[rd_k];
	end

	always_ff @(posedge clk) begin
		if (cmd.we_azp) begin
			azp_mem[MW'(row_index)] <= elem_value;
		end
		if (cmd.start) begin
			azp_raw_q <= azp_mem[(cfg.a_zero_mode == i8mmzp_pkg::ZP_SCALAR) ?
				MW'(0) : MW'(row_index)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.we_bzp) begin
			bzp_q[NW'(row_index)] <= elem_value;
		end
		if (cmd.start) begin
			row_q <= row_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	assign status.pipe_busy = v_s1 | v_s2;

	always_comb begin
		case (cfg.a_zero_mode)
			i8mmzp_pkg::ZP_SCALAR,
			i8mmzp_pkg::ZP_PER: azp = i8mmzp_pkg::widen(azp_raw_q, cfg.a_is_signed);
			default:            azp = '0;
		endcase
		da = i8mmzp_pkg::widen(a_rd_s1, cfg.a_is_signed) - azp;
	end

	for (genvar j = 0; j < MAX_N; j++) begin : g_lane
		logic signed [DW-1:0] bzp;
		logic signed [DW-1:0] db;

		always_comb begin
			case (cfg.b_zero_mode)
				i8mmzp_pkg::ZP_SCALAR: bzp = i8mmzp_pkg::widen(bzp_q[0], cfg.b_is_signed);
				i8mmzp_pkg::ZP_PER:    bzp = i8mmzp_pkg::widen(bzp_q[j], cfg.b_is_signed);
				default:               bzp = '0;
			endcase
			db = i8mmzp_pkg::widen(b_rd_s1[j*EW +: EW], cfg.b_is_signed) - bzp;
		end

		always_ff @(posedge clk) begin
			prod_s2[j] <= da * db;
			if (cmd.start) begin
				acc_q[j] <= '0;
			end else if (v_s2) begin
				acc_q[j] <= acc_q[j] + SW'(prod_s2[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_row  <= row_q;
			res_col  <= i8mmzp_pkg::IDX_W'(out_col);
			res_sum  <= acc_q[out_col];
			res_last <= cmd.out_last;
		end
	end

endmodule

### src/i8mmzp_ctrl.sv
// Controller of the int8 matmul core: item decode, reduction sequencing,
// result emission and output valid. Depends on i8mmzp_pkg and the macro header.
`timescale 1ns / 1ps
`include "int8_matmul_with_zero_points_core_macros.svh"

module i8mmzp_ctrl #(
	parameter int MAX_M = i8mmzp_pkg::DEF_MAX_M,
	parameter int MAX_K = i8mmzp_pkg::DEF_MAX_K,
	parameter int MAX_N = i8mmzp_pkg::DEF_MAX_N,
	localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1,
	localparam int NW = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i8mmzp_pkg::cfg_t              cfg,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [i8mmzp_pkg::OP_W-1:0]   op,
	input  logic [i8mmzp_pkg::IDX_W-1:0]  row_index,
	input  logic [i8mmzp_pkg::IDX_W-1:0]  col_index,
	output logic                          result_valid,
	input  logic                          result_ready,
	output i8mmzp_pkg::cmd_t              cmd,
	output logic [KW-1:0]                 rd_k,
	output logic [NW-1:0]                 out_col,
	input  i8mmzp_pkg::status_t           status
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	logic [KW-1:0] k_q, k_d, k_last_q, k_last_d;
	logic [NW-1:0] col_q, col_d, n_last_q, n_last_d;
	logic          out_valid_q;
	logic          fire;
	logic          row_ok;
	logic [7:0]    m_last;

	assign fire   = item_valid && item_ready;
	assign m_last = i8mmzp_pkg::last_index(cfg.dim_m, MAX_M);
	assign row_ok = 8'(row_index) <= m_last;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign rd_k         = k_q;
	assign out_col      = col_q;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		col_d    = col_q;
		k_last_d = k_last_q;
		n_last_d = n_last_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					case (op)
						i8mmzp_pkg::OP_LOAD_A:
							cmd.we_a = (9'(row_index) < 9'(MAX_M)) &&
								(9'(col_index) < 9'(MAX_K));
						i8mmzp_pkg::OP_LOAD_B:
							cmd.we_b = (9'(row_index) < 9'(MAX_K)) &&
								(9'(col_index) < 9'(MAX_N));
						i8mmzp_pkg::OP_LOAD_AZP:
							cmd.we_azp = 9'(row_index) < 9'(MAX_M);
						i8mmzp_pkg::OP_LOAD_BZP:
							cmd.we_bzp = 9'(row_index) < 9'(MAX_N);
						i8mmzp_pkg::OP_COMPUTE: begin
							if (row_ok) begin
								cmd.start = 1'b1;
								k_d       = '0;
								k_last_d  = KW'(i8mmzp_pkg::last_index(cfg.dim_k, MAX_K));
								n_last_d  = NW'(i8mmzp_pkg::last_index(cfg.dim_n, MAX_N));
								state_d   = ST_RUN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				cmd.rd_en = 1'b1;
				if (k_q == k_last_q) begin
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					col_d   = '0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (col_q == n_last_q);
					if (col_q == n_last_q) begin
						state_d = ST_IDLE;
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			k_last_q    <= '0;
			col_q       <= '0;
			n_last_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			k_q      <= k_d;
			k_last_q <= k_last_d;
			col_q    <= col_d;
			n_last_q <= n_last_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`I8MMZP_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || result_ready, "output register overwritten before its transaction")
	`I8MMZP_ASSERT_NXT(a_rd_fills_pipe, clk, arst_n, cmd.rd_en, status.pipe_busy, "reduction step did not enter the MAC pipeline")
	`I8MMZP_ASSERT_IMP(a_idle_drained, clk, arst_n, state_q == ST_IDLE, !status.pipe_busy, "MAC pipeline busy while idle")
	`I8MMZP_ASSERT_NXT(a_last_ends_row, clk, arst_n, cmd.out_load && cmd.out_last, state_q == ST_IDLE, "row did not end after its last column")
	`I8MMZP_ASSERT_IMP(a_k_in_range, clk, arst_n, state_q == ST_RUN, k_q <= k_last_q, "reduction index past the last step")

endmodule

### tb/sv/i8mmzp_sum_checker.sv
`timescale 1ns / 1ps
// Result checker for the int8 matmul core: mirrors config and stores from the
// observed transactions, predicts each row's dot sums, compares them in order.
// Depends on i8mmzp_pkg and the channel interfaces of i8mmzp_if.sv.

module i8mmzp_sum_checker (
	input  logic         clk,
	input  logic         arst_n,
	i8mmzp_item_if       item_mon,
	i8mmzp_result_if     result_mon,
	i8mmzp_cfg_if        cfg_mon,
	output int unsigned  mismatch_count,
	output int unsigned  sums_outstanding,
	output int unsigned  sums_received
);
	import i8mmzp_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [SUM_W-1:0] sum;
		logic                    last;
	} dot_sum_t;

	cfg_t            mirror;
	logic [ELEM_W-1:0] a_bytes [DEF_MAX_M][DEF_MAX_K];
	logic [ELEM_W-1:0] b_bytes [DEF_MAX_K][DEF_MAX_N];
	logic [ELEM_W-1:0] a_zp [DEF_MAX_M];
	logic [ELEM_W-1:0] b_zp [DEF_MAX_N];
	dot_sum_t        sums_due [$];

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] dim,
			input int unsigned ceiling);
		if (dim == '0) return 1;
		if (dim > ceiling) return ceiling;
		return dim;
	endfunction

	function automatic int as_int(input logic [ELEM_W-1:0] raw, input logic sgn);
		if (sgn && raw[ELEM_W-1]) return int'(raw) - 256;
		return int'(raw);
	endfunction

	function automatic int a_offset(input int unsigned row);
		case (mirror.a_zero_mode)
			ZP_SCALAR: return as_int(a_zp[0], mirror.a_is_signed);
			ZP_PER:    return as_int(a_zp[row], mirror.a_is_signed);
			default:   return 0;
		endcase
	endfunction

	function automatic int b_offset(input int unsigned col);
		case (mirror.b_zero_mode)
			ZP_SCALAR: return as_int(b_zp[0], mirror.b_is_signed);
			ZP_PER:    return as_int(b_zp[col], mirror.b_is_signed);
			default:   return 0;
		endcase
	endfunction

	// one compute transaction: dim_n sums for the row, last column flagged
	function automatic void queue_row_sums(input int unsigned row);
		int unsigned rows, depth, cols;
		int azp, bzp, acc;
		dot_sum_t rec;
		rows  = clamp_dim(mirror.dim_m, DEF_MAX_M);
		depth = clamp_dim(mirror.dim_k, DEF_MAX_K);
		cols  = clamp_dim(mirror.dim_n, DEF_MAX_N);
		if (row >= rows) return;
		azp = a_offset(row);
		for (int j = 0; j < cols; j++) begin
			bzp = b_offset(j);
			acc = 0;
			for (int t = 0; t < depth; t++) begin
				acc += (as_int(a_bytes[row][t], mirror.a_is_signed) - azp) *
					(as_int(b_bytes[t][j], mirror.b_is_signed) - bzp);
			end
			rec.row  = IDX_W'(row);
			rec.col  = IDX_W'(j);
			rec.sum  = acc;
			rec.last = (j + 1 == cols);
			sums_due.push_back(rec);
		end
	endfunction

	function automatic void log_bad(input bit have_want, input dot_sum_t want);
		mismatch_count++;
		if (mismatch_count > REPORT_LIMIT) return;
		if (have_want)
			$display("%0t mismatch: expected row %0d col %0d sum %0d last %0b",
				$time, want.row, want.col, want.sum, want.last);
		else
			$display("%0t mismatch: no sum expected", $time);
		$display("%0t          got row %0d col %0d sum %0d last %0b", $time,
			result_mon.out_row, result_mon.out_col, result_mon.dot_sum,
			result_mon.is_last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dot_sum_t want;
		if (!arst_n) begin
			mirror = '{dim_m: 1, dim_k: 1, dim_n: 1, a_is_signed: 1'b1,
				b_is_signed: 1'b1, a_zero_mode: ZP_NONE, b_zero_mode: ZP_NONE};
			sums_due.delete();
			mismatch_count   = 0;
			sums_outstanding = 0;
			sums_received    = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					REG_DIM_M:       mirror.dim_m = cfg_mon.data;
					REG_DIM_K:       mirror.dim_k = cfg_mon.data;
					REG_DIM_N:       mirror.dim_n = cfg_mon.data;
					REG_A_IS_SIGNED: mirror.a_is_signed = cfg_mon.data[0];
					REG_B_IS_SIGNED: mirror.b_is_signed = cfg_mon.data[0];
					REG_A_ZERO_MODE: mirror.a_zero_mode = cfg_mon.data[1:0];
					REG_B_ZERO_MODE: mirror.b_zero_mode = cfg_mon.data[1:0];
					default: ;
				endcase
			end
			if (item_mon.valid && item_mon.ready) begin
				case (item_mon.op)
					OP_LOAD_A:   a_bytes[item_mon.row_index][item_mon.col_index] =
						item_mon.elem_value;
					OP_LOAD_B:   b_bytes[item_mon.row_index][item_mon.col_index] =
						item_mon.elem_value;
					OP_LOAD_AZP: a_zp[item_mon.row_index] = item_mon.elem_value;
					OP_LOAD_BZP: b_zp[item_mon.row_index] = item_mon.elem_value;
					OP_COMPUTE:  queue_row_sums(item_mon.row_index);
					default: ;
				endcase
			end
			if (result_mon.valid && result_mon.ready) begin
				sums_received++;
				if (sums_due.size() == 0) begin
					log_bad(1'b0, '0);
				end else begin
					want = sums_due.pop_front();
					if (want.row !== result_mon.out_row || want.col !== result_mon.out_col ||
							want.sum !== result_mon.dot_sum ||
							want.last !== result_mon.is_last)
						log_bad(1'b1, want);
				end
			end
			sums_outstanding = sums_due.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the int8 matmul core testbench: clock, reset, stimulus and verdict.
// Depends on i8mmzp_pkg, i8mmzp_if.sv, the core and i8mmzp_sum_checker.

module tb;
	import i8mmzp_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_ITEMS  = 250;
	localparam int FIXED_ITEMS   = 20;      // random items per fixed config
	localparam int PHASE_ITEMS   = 30;      // random items per random config
	localparam int MAX_GAP       = 12;
	localparam int LONG_HOLD     = 400;     // cycles the result side backs off once
	localparam int HOLD_AT       = 150;     // random item count that triggers it
	localparam int SETTLE_CYCLES = 20;      // covers loads and empty computes in flight
	localparam int B_BUDGET      = 512;     // cap on k*n so B refills stay cheap
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int DIM_TOP       = (1 << DIM_W) - 1;

	// codes the package leaves unnamed
	localparam logic [REG_IDX_W-1:0] REG_SPARE       = 3'd7;
	localparam logic [OP_W-1:0]      OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0]      OP_UNUSED_LAST  = 3'd7;
	localparam logic [1:0]           ZP_SPARE        = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	i8mmzp_item_if   item_ch ();
	i8mmzp_result_if result_ch ();
	i8mmzp_cfg_if    cfg_ch ();

	int unsigned mismatch_count;
	int unsigned sums_outstanding;
	int unsigned sums_received;
	int unsigned cycle_count = 0;

	// stimulus-side view: live config and which store entries hold data
	cfg_t        now_cfg;
	bit          a_set [DEF_MAX_M][DEF_MAX_K];
	bit          b_set [DEF_MAX_K][DEF_MAX_N];
	bit          send_idle;
	bit          take_idle;
	bit          backlog_req;
	bit          backlog_done;
	int unsigned items_drawn;

	int8_matmul_with_zero_points_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	i8mmzp_sum_checker sum_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_mon         (item_ch),
		.result_mon       (result_ch),
		.cfg_mon          (cfg_ch),
		.mismatch_count   (mismatch_count),
		.sums_outstanding (sums_outstanding),
		.sums_received    (sums_received)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// hard stop in case the core hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** int8_matmul_with_zero_points_core: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned live_dim(input logic [DIM_W-1:0] dim,
			input int unsigned ceiling);
		if (dim == '0) return 1;
		if (dim > ceiling) return ceiling;
		return dim;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;                                      // acts as 1
		if (r == 1) return DIM_W'($urandom_range(DEF_MAX_M + 1, DIM_TOP));  // clamps
		if (r == 2) return DIM_W'($urandom_range(7, DEF_MAX_M));
		return DIM_W'($urandom_range(1, 6));
	endfunction

	// One item transaction. Entered and left at a falling edge; valid stays high
	// after acceptance so back-to-back items never toggle it within a step.
	task automatic push_item(input logic [OP_W-1:0] op, input int unsigned row,
			input int unsigned col, input logic [ELEM_W-1:0] value);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.op         <= op;
		item_ch.row_index  <= IDX_W'(row);
		item_ch.col_index  <= IDX_W'(col);
		item_ch.elem_value <= value;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		if (op == OP_LOAD_A) a_set[row][col] = 1'b1;
		if (op == OP_LOAD_B) b_set[row][col] = 1'b1;
	endtask

	// Wait out every pending sum, then settle for loads or
	// empty computes that produce nothing.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (sums_outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] index, input int unsigned data);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			cfg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= CFG_DATA_W'(data);
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Full register set, written only once the core has gone quiet.
	task automatic apply_config(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
			input logic [DIM_W-1:0] n, input logic a_sg, input logic b_sg,
			input logic [1:0] a_zm, input logic [1:0] b_zm, input bit with_spare);
		wait_idle();
		if (with_spare) write_reg(REG_SPARE, $urandom_range(0, DIM_TOP));
		write_reg(REG_DIM_M, m);
		write_reg(REG_DIM_K, k);
		write_reg(REG_DIM_N, n);
		write_reg(REG_A_IS_SIGNED, a_sg);
		write_reg(REG_B_IS_SIGNED, b_sg);
		write_reg(REG_A_ZERO_MODE, a_zm);
		write_reg(REG_B_ZERO_MODE, b_zm);
		cfg_ch.valid <= 1'b0;
		now_cfg = '{dim_m: m, dim_k: k, dim_n: n, a_is_signed: a_sg, b_is_signed: b_sg,
			a_zero_mode: a_zm, b_zero_mode: b_zm};
		send_idle = $urandom_range(0, 3) != 0;
		take_idle = $urandom_range(0, 3) != 0;
	endtask

	// Load whatever the row still lacks (A row, the live block of B), then
	// compute it. Zero points are all seeded up front.
	task automatic fill_and_compute(input int unsigned row);
		int unsigned depth, cols;
		depth = live_dim(now_cfg.dim_k, DEF_MAX_K);
		cols  = live_dim(now_cfg.dim_n, DEF_MAX_N);
		for (int t = 0; t < depth; t++)
			if (!a_set[row][t]) push_item(OP_LOAD_A, row, t, ELEM_W'($urandom));
		for (int t = 0; t < depth; t++)
			for (int j = 0; j < cols; j++)
				if (!b_set[t][j]) push_item(OP_LOAD_B, t, j, ELEM_W'($urandom));
		push_item(OP_COMPUTE, row, $urandom_range(0, DEF_MAX_K - 1), ELEM_W'($urandom));
	endtask

	// Mixed traffic under the live config: mostly well-formed row computes,
	// element and zero-point overwrites inside the live window, some loads
	// anywhere, rows past dim_m, and unused op codes (not counted).
	task automatic random_burst(input int unsigned count);
		int unsigned done_items, pick, rows, depth, cols, row, col;
		logic [OP_W-1:0] op;
		done_items = 0;
		while (done_items < count) begin
			rows  = live_dim(now_cfg.dim_m, DEF_MAX_M);
			depth = live_dim(now_cfg.dim_k, DEF_MAX_K);
			cols  = live_dim(now_cfg.dim_n, DEF_MAX_N);
			pick  = $urandom_range(0, 99);
			if (pick >= 93) begin
				op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
				push_item(op, $urandom_range(0, DEF_MAX_M - 1),
					$urandom_range(0, DEF_MAX_K - 1), ELEM_W'($urandom));
			end else begin
				if (pick < 45) begin
					fill_and_compute($urandom_range(0, rows - 1));
				end else if (pick < 72) begin
					op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
					if ($urandom_range(0, 3) != 0) begin
						row = $urandom_range(0, (op == OP_LOAD_A ? rows : depth) - 1);
						col = $urandom_range(0, (op == OP_LOAD_A ? depth : cols) - 1);
					end else begin
						row = $urandom_range(0, DEF_MAX_M - 1);
						col = $urandom_range(0, DEF_MAX_K - 1);
					end
					push_item(op, row, col, ELEM_W'($urandom));
				end else if (pick < 82) begin
					op = $urandom_range(0, 1) ? OP_LOAD_BZP : OP_LOAD_AZP;
					row = $urandom_range(0, 1) ? $urandom_range(0, DEF_MAX_M - 1) :
						$urandom_range(0, (op == OP_LOAD_AZP ? rows : cols) - 1);
					push_item(op, row, $urandom_range(0, DEF_MAX_K - 1), ELEM_W'($urandom));
				end else if (rows < DEF_MAX_M) begin
					// row past dim_m: accepted, no sums
					push_item(OP_COMPUTE, $urandom_range(rows, DEF_MAX_M - 1),
						$urandom_range(0, DEF_MAX_K - 1), ELEM_W'($urandom));
				end else begin
					fill_and_compute($urandom_range(0, rows - 1));
				end
				done_items++;
				items_drawn++;
				if (items_drawn == HOLD_AT) backlog_req = 1'b1;
			end
		end
	endtask

	// Result side: a random back-off before each sum, and once a long one so
	// the core backs up and stalls the item channel while items keep coming.
	initial begin : take_side
		int unsigned gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (backlog_req && !backlog_done) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				backlog_done = 1'b1;
			end
			gap = take_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			@(negedge clk);
		end
	end

	initial begin : send_side
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.op           = OP_LOAD_A;
		item_ch.row_index    = '0;
		item_ch.col_index    = '0;
		item_ch.elem_value   = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = REG_DIM_M;
		cfg_ch.data          = '0;
		send_idle            = 1'b1;
		take_idle            = 1'b1;
		backlog_req          = 1'b0;
		backlog_done         = 1'b0;
		items_drawn          = 0;
		now_cfg = '{dim_m: 1, dim_k: 1, dim_n: 1, a_is_signed: 1'b1, b_is_signed: 1'b1,
			a_zero_mode: ZP_NONE, b_zero_mode: ZP_NONE};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Seed every zero point so no mode ever reads an empty entry.
		for (int i = 0; i < DEF_MAX_M; i++) push_item(OP_LOAD_AZP, i, 0, ELEM_W'($urandom));
		for (int i = 0; i < DEF_MAX_N; i++) push_item(OP_LOAD_BZP, i, 0, ELEM_W'($urandom));

		// Directed, under the reset config (1x1x1, int8, no zero points).
		push_item(OP_LOAD_A, 0, 0, 8'h80);
		push_item(OP_LOAD_B, 0, 0, 8'h80);
		push_item(OP_COMPUTE, 0, 0, 8'h00);            // -128 * -128
		push_item(OP_LOAD_B, 0, 0, 8'h7F);
		push_item(OP_COMPUTE, 0, DEF_MAX_K - 1, 8'hFF); // -128 * 127
		push_item(OP_LOAD_A, 0, 0, 8'hFF);
		push_item(OP_LOAD_B, 0, 0, 8'h00);
		push_item(OP_COMPUTE, 0, 0, 8'h00);            // zero product
		// unused op codes: dropped without a sum
		for (int o = OP_UNUSED_FIRST; o <= OP_UNUSED_LAST; o++)
			push_item(OP_W'(o), DEF_MAX_M - 1, DEF_MAX_K - 1, 8'hFF);
		// rows past dim_m: accepted, no sums
		push_item(OP_COMPUTE, 1, 0, 8'h00);
		push_item(OP_COMPUTE, DEF_MAX_M - 1, DEF_MAX_K - 1, 8'hFF);
		// loads at the far corners of every store
		push_item(OP_LOAD_A, DEF_MAX_M - 1, DEF_MAX_K - 1, 8'hFF);
		push_item(OP_LOAD_B, DEF_MAX_K - 1, DEF_MAX_N - 1, 8'h00);
		push_item(OP_LOAD_AZP, DEF_MAX_M - 1, DEF_MAX_K - 1, 8'h7F);
		push_item(OP_LOAD_BZP, DEF_MAX_N - 1, 0, 8'h80);
		push_item(OP_COMPUTE, 0, 0, 8'h00);

		// Largest magnitude, int8: 64 steps of (-128 - 127) * (127 + 128).
		apply_config(1, DEF_MAX_K, 1, 1'b1, 1'b1, ZP_SCALAR, ZP_SCALAR, 1'b1);
		for (int t = 0; t < DEF_MAX_K; t++) begin
			push_item(OP_LOAD_A, 0, t, 8'h80);
			push_item(OP_LOAD_B, t, 0, 8'h7F);
		end
		push_item(OP_LOAD_AZP, 0, 0, 8'h7F);
		push_item(OP_LOAD_BZP, 0, 0, 8'h80);
		push_item(OP_COMPUTE, 0, 0, 8'h00);
		// Same for uint8: 64 steps of (255 - 0) * (0 - 255).
		apply_config(1, DEF_MAX_K, 1, 1'b0, 1'b0, ZP_SCALAR, ZP_SCALAR, 1'b0);
		for (int t = 0; t < DEF_MAX_K; t++) begin
			push_item(OP_LOAD_A, 0, t, 8'hFF);
			push_item(OP_LOAD_B, t, 0, 8'h00);
		end
		push_item(OP_LOAD_AZP, 0, 0, 8'h00);
		push_item(OP_LOAD_BZP, 0, 0, 8'hFF);
		push_item(OP_COMPUTE, 0, 0, 8'h00);

		// Fixed configs: every zero mode and signedness mix, the largest
		// dims, zero dims (act as 1) and dims past the maximum (clamp).
		apply_config(4, 3, 5, 1'b1, 1'b1, ZP_SCALAR, ZP_PER, 1'b0);
		random_burst(FIXED_ITEMS);
		apply_config(DEF_MAX_M, 1, DEF_MAX_N, 1'b0, 1'b0, ZP_PER, ZP_SCALAR, 1'b0);
		random_burst(FIXED_ITEMS);
		apply_config(2, DEF_MAX_K, 1, 1'b1, 1'b0, ZP_PER, ZP_PER, 1'b0);
		random_burst(FIXED_ITEMS);
		apply_config(0, 0, 0, 1'b0, 1'b1, ZP_SPARE, ZP_SPARE, 1'b0);
		random_burst(FIXED_ITEMS);
		apply_config(DIM_TOP, DIM_TOP, 2, 1'b1, 1'b1, ZP_NONE, ZP_PER, 1'b0);
		random_burst(FIXED_ITEMS);
		apply_config(3, 2, 100, 1'b0, 1'b1, ZP_SCALAR, ZP_NONE, 1'b0);
		random_burst(FIXED_ITEMS);

		// Random configs until the random item count is reached.
		while (items_drawn < RANDOM_ITEMS) begin : random_phase
			logic [DIM_W-1:0] m, k, n;
			m = pick_dim();
			k = pick_dim();
			n = pick_dim();
			while (live_dim(k, DEF_MAX_K) * live_dim(n, DEF_MAX_N) > B_BUDGET)
				n = DIM_W'($urandom_range(1, 6));
			apply_config(m, k, n, $urandom_range(0, 1), $urandom_range(0, 1),
				2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0);
			random_burst(PHASE_ITEMS);
		end

		wait_idle();
		if (mismatch_count == 0 && sums_outstanding == 0) begin
			$display("** int8_matmul_with_zero_points_core: PASSED **");
		end else begin
			$display("** int8_matmul_with_zero_points_core: FAILED **");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/i8mmzp_pkg.sv
src/i8mmzp_if.sv
src/i8mmzp_cfg.sv
src/i8mmzp_dp.sv
src/i8mmzp_ctrl.sv
src/int8_matmul_with_zero_points_core.sv
tb/sv/i8mmzp_sum_checker.sv
tb/sv/tb.sv
